@@ hdl/range_add_point_query_tree_top_macros.svh @@
// Assertion macros for the range add / point query tree.
// Used by the port-level checker only; clock is aclk, reset is aresetn.
`ifndef RANGE_ADD_POINT_QUERY_TREE_TOP_MACROS_SVH
`define RANGE_ADD_POINT_QUERY_TREE_TOP_MACROS_SVH

// next-cycle implication, off while reset is asserted
`define RAPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also holds across reset
`define RAPQ_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/rapq_pkg.sv @@
// Shared constants for the range add / point query tree.
// No dependencies.
package rapq_pkg;
    localparam int MAX_ELEMENTS_DEF = 1024;
    localparam int DATA_W = 64;
    localparam int SIZE_W = 11;
    localparam int POS_IN_W = 10;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_ADD   = 2'd1;
    localparam logic [1:0] FUNC_QUERY = 2'd2;
endpackage

@@ hdl/rapq_mem.sv @@
// Node store: one write port, one registered read port.
// Depends on rapq_pkg for the data width.
module rapq_mem #(
    parameter int DEPTH = 4096,
    parameter int AW = 12
) (
    input  logic                        aclk,
    input  logic                        we,
    input  logic [AW-1:0]               waddr,
    input  logic [rapq_pkg::DATA_W-1:0] wdata,
    input  logic                        re,
    input  logic [AW-1:0]               raddr,
    output logic [rapq_pkg::DATA_W-1:0] rdata
);
    logic [rapq_pkg::DATA_W-1:0] mem [DEPTH];
    logic [rapq_pkg::DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        // hold the last read word until the next read
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

@@ hdl/rapq_ctrl.sv @@
// Sequencer for the tree: clearing sweep, root-to-leaf walk, range add traversal.
// Depends on rapq_pkg; drives the node store in rapq_mem.
module rapq_ctrl #(
    parameter int MAX_ELEMENTS = rapq_pkg::MAX_ELEMENTS_DEF,
    parameter int AW = 12
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [rapq_pkg::SIZE_W-1:0]         cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_func,
    input  logic [rapq_pkg::POS_IN_W-1:0]       s_position,
    input  logic [rapq_pkg::POS_IN_W-1:0]       s_range_high,
    input  logic signed [rapq_pkg::DATA_W-1:0]  s_amount,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [rapq_pkg::DATA_W-1:0]  m_element_value,
    output logic                                mem_we,
    output logic [AW-1:0]                       mem_waddr,
    output logic [rapq_pkg::DATA_W-1:0]         mem_wdata,
    output logic                                mem_re,
    output logic [AW-1:0]                       mem_raddr,
    input  logic [rapq_pkg::DATA_W-1:0]         mem_rdata
);
    localparam int LG = $clog2(MAX_ELEMENTS);
    localparam int PW = ((LG > rapq_pkg::SIZE_W) ? LG : rapq_pkg::SIZE_W) + 1;
    localparam int SD = LG + 2;
    localparam int SIW = $clog2(SD);
    localparam int SPW = $clog2(SD + 1);
    localparam int DW = rapq_pkg::DATA_W;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_WALK  = 3'd2;
    localparam logic [2:0] ST_LAST  = 3'd3;
    localparam logic [2:0] ST_VISIT = 3'd4;
    localparam logic [2:0] ST_ADDRD = 3'd5;

    logic [2:0]                  state_reg, state_next;
    logic [rapq_pkg::SIZE_W-1:0] size_reg, size_next;
    logic [AW-1:0]               clr_cnt_reg, clr_cnt_next;
    logic [1:0]                  func_reg, func_next;
    logic [PW-1:0]               pos_reg, pos_next;
    logic [PW-1:0]               high_reg, high_next;
    logic [DW-1:0]               amt_reg, amt_next;
    logic [AW-1:0]               id_reg, id_next;
    logic [PW-1:0]               lo_reg, lo_next;
    logic [PW-1:0]               hi_reg, hi_next;
    logic [DW-1:0]               sum_reg, sum_next;
    logic                        rdv_reg, rdv_next;
    logic [SPW-1:0]              sp_reg, sp_next;
    logic                        m_valid_reg, m_valid_next;
    logic [DW-1:0]               m_data_reg, m_data_next;

    logic [AW-1:0] stk_id [SD];
    logic [PW-1:0] stk_lo [SD];
    logic [PW-1:0] stk_hi [SD];
    logic          push;
    logic          pop;

    logic [PW-1:0] size_ext;
    logic [PW-1:0] n_act;
    logic [PW-1:0] mid;
    logic [PW-1:0] in_pos;
    logic [PW-1:0] in_high;
    logic          out_free;
    logic          disjoint;
    logic          covered;
    logic [SIW-1:0] top_idx;

    assign size_ext = PW'(size_reg);
    assign in_pos   = PW'(s_position);
    assign in_high  = PW'(s_range_high);
    assign mid      = PW'(({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1);
    assign out_free = !m_valid_reg || m_ready;
    assign disjoint = (hi_reg < pos_reg) || (lo_reg > high_reg);
    assign covered  = (pos_reg <= lo_reg) && (hi_reg <= high_reg);
    assign top_idx  = SIW'(sp_reg - SPW'(1));

    always_comb begin
        if (size_ext == '0) begin
            n_act = PW'(1);
        end else if (size_ext > PW'(MAX_ELEMENTS)) begin
            n_act = PW'(MAX_ELEMENTS);
        end else begin
            n_act = size_ext;
        end
    end

    always_comb begin
        state_next   = state_reg;
        size_next    = size_reg;
        clr_cnt_next = clr_cnt_reg;
        func_next    = func_reg;
        pos_next     = pos_reg;
        high_next    = high_reg;
        amt_next     = amt_reg;
        id_next      = id_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        sum_next     = sum_reg;
        rdv_next     = rdv_reg;
        sp_next      = sp_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        mem_we       = 1'b0;
        mem_waddr    = id_reg;
        mem_wdata    = '0;
        mem_re       = 1'b0;
        mem_raddr    = id_reg;
        push         = 1'b0;
        pop          = 1'b0;

        case (state_reg)
            ST_CLEAR: begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(4 * MAX_ELEMENTS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    func_next = s_func;
                    pos_next  = in_pos;
                    high_next = in_high;
                    amt_next  = s_amount;
                    id_next   = AW'(1);
                    lo_next   = '0;
                    hi_next   = n_act - PW'(1);
                    sum_next  = '0;
                    rdv_next  = 1'b0;
                    sp_next   = '0;
                    case (s_func)
                        rapq_pkg::FUNC_LOAD: begin
                            if (in_pos < n_act) begin
                                state_next = ST_WALK;
                            end
                        end
                        rapq_pkg::FUNC_QUERY: begin
                            // clamp a query past the end to the last element
                            if (in_pos >= n_act) begin
                                pos_next = n_act - PW'(1);
                            end
                            state_next = ST_WALK;
                        end
                        rapq_pkg::FUNC_ADD: begin
                            if (in_pos <= in_high) begin
                                state_next = ST_VISIT;
                            end
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_WALK: begin
                // ancestors accumulate into sum; no push-down is needed
                if (rdv_reg) begin
                    sum_next = sum_reg + mem_rdata;
                end
                mem_re   = 1'b1;
                rdv_next = 1'b1;
                if (lo_reg == hi_reg) begin
                    state_next = ST_LAST;
                end else if (pos_reg <= mid) begin
                    id_next = {id_reg[AW-2:0], 1'b0};
                    hi_next = mid;
                end else begin
                    id_next = {id_reg[AW-2:0], 1'b1};
                    lo_next = mid + PW'(1);
                end
            end
            ST_LAST: begin
                if (func_reg == rapq_pkg::FUNC_QUERY) begin
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        m_data_next  = sum_reg + mem_rdata;
                        state_next   = ST_IDLE;
                    end
                end else begin
                    // leaf holds the loaded value less the ancestors' pending sum
                    mem_we     = 1'b1;
                    mem_wdata  = amt_reg - sum_reg;
                    state_next = ST_IDLE;
                end
            end
            ST_VISIT: begin
                if (disjoint) begin
                    pop = 1'b1;
                end else if (covered) begin
                    mem_re     = 1'b1;
                    state_next = ST_ADDRD;
                end else begin
                    push    = 1'b1;
                    sp_next = sp_reg + SPW'(1);
                    id_next = {id_reg[AW-2:0], 1'b0};
                    hi_next = mid;
                end
            end
            ST_ADDRD: begin
                mem_we    = 1'b1;
                mem_wdata = mem_rdata + amt_reg;
                pop       = 1'b1;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (pop) begin
            if (sp_reg == '0) begin
                state_next = ST_IDLE;
            end else begin
                sp_next    = sp_reg - SPW'(1);
                id_next    = stk_id[top_idx];
                lo_next    = stk_lo[top_idx];
                hi_next    = stk_hi[top_idx];
                state_next = ST_VISIT;
            end
        end

        // a size write restarts the clearing sweep
        if (cfg_we) begin
            size_next    = cfg_data;
            clr_cnt_next = '0;
            state_next   = ST_CLEAR;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            size_reg    <= rapq_pkg::SIZE_RESET;
            clr_cnt_reg <= '0;
            sp_reg      <= '0;
            rdv_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            size_reg    <= size_next;
            clr_cnt_reg <= clr_cnt_next;
            sp_reg      <= sp_next;
            rdv_reg     <= rdv_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg   <= func_next;
        pos_reg    <= pos_next;
        high_reg   <= high_next;
        amt_reg    <= amt_next;
        id_reg     <= id_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        sum_reg    <= sum_next;
        m_data_reg <= m_data_next;
        if (push) begin
            stk_id[SIW'(sp_reg)] <= {id_reg[AW-2:0], 1'b1};
            stk_lo[SIW'(sp_reg)] <= mid + PW'(1);
            stk_hi[SIW'(sp_reg)] <= hi_reg;
        end
    end

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_element_value = m_data_reg;
endmodule

@@ hdl/range_add_point_query_tree_top.sv @@
// Channel   Handshake              Word
// s_        s_valid / s_ready      s_func, s_position, s_range_high, s_amount
// m_        m_valid / m_ready      m_element_value
// cfg_      cfg_we (no wait)       cfg_data (size_in_use)
//
// Load and query walk root to leaf one node a cycle.
// A range add visits each split or missed node once and reads, then writes back, each
// covered node through the store's single read port: up to about 4 nodes per level.
// Reset and every size write run a clearing sweep of 4*MAX_ELEMENTS words; s_ready is low.
// A finished query result waits in the output register; a new word is taken meanwhile.
module range_add_point_query_tree_top #(
    parameter int MAX_ELEMENTS = rapq_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [rapq_pkg::SIZE_W-1:0]         cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_func,
    input  logic [rapq_pkg::POS_IN_W-1:0]       s_position,
    input  logic [rapq_pkg::POS_IN_W-1:0]       s_range_high,
    input  logic signed [rapq_pkg::DATA_W-1:0]  s_amount,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [rapq_pkg::DATA_W-1:0]  m_element_value
);
    localparam int DEPTH = 4 * MAX_ELEMENTS;
    localparam int AW = $clog2(DEPTH);

    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [rapq_pkg::DATA_W-1:0] mem_wdata;
    logic                        mem_re;
    logic [AW-1:0]               mem_raddr;
    logic [rapq_pkg::DATA_W-1:0] mem_rdata;

    rapq_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    rapq_ctrl #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .AW           (AW)
    ) u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_position      (s_position),
        .s_range_high    (s_range_high),
        .s_amount        (s_amount),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_element_value (m_element_value),
        .mem_we          (mem_we),
        .mem_waddr       (mem_waddr),
        .mem_wdata       (mem_wdata),
        .mem_re          (mem_re),
        .mem_raddr       (mem_raddr),
        .mem_rdata       (mem_rdata)
    );
endmodule

@@ hdl/rapq_checker.sv @@
// Port-level checks for range_add_point_query_tree_top, attached by bind.
// Depends on rapq_pkg and range_add_point_query_tree_top_macros.svh.
`include "range_add_point_query_tree_top_macros.svh"

module rapq_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                cfg_we,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic [1:0]                          s_func,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic signed [rapq_pkg::DATA_W-1:0]  m_element_value
);
    // clearing sweep follows reset
    `RAPQ_ASSERT_NEXT_ALWAYS(a_reset_clears, !aresetn, !s_ready, "ready right after reset")
    // a size write restarts the sweep
    `RAPQ_ASSERT_NEXT(a_cfg_clears, cfg_we, !s_ready, "ready right after size write")
    // a query word takes the block out of idle to walk the tree
    `RAPQ_ASSERT_NEXT(a_query_busy, s_valid && s_ready && s_func == rapq_pkg::FUNC_QUERY,
        !s_ready, "ready right after a query word")
    `RAPQ_ASSERT_NEXT(a_out_hold, m_valid && !m_ready,
        m_valid && $stable(m_element_value), "stalled result word changed")
endmodule

bind range_add_point_query_tree_top rapq_checker u_rapq_checker (.*);
